// ===== hw/rtl/oei_pkg.sv =====
// ----------------------------------------------------------------------------
// oei_pkg
// Shared widths, register indexes and sequencer states for the integrator.
// ----------------------------------------------------------------------------
package oei_pkg;

  localparam int unsigned DataW = 48;
  localparam int unsigned HalfW = 24;
  localparam int unsigned ProdW = 96;
  localparam int unsigned CfgIdxW = 3;

  typedef logic signed [DataW-1:0] word_t;
  typedef logic [DataW-1:0] uword_t;
  typedef logic [ProdW-1:0] prod_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INV_MASS  = 3'd0,
    CFG_THRUST_X  = 3'd1,
    CFG_THRUST_Y  = 3'd2,
    CFG_THRUST_Z  = 3'd3,
    CFG_STEP_TIME = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_DIV,
    ST_THR,
    ST_CEN,
    ST_VEL,
    ST_POS,
    ST_OUT
  } state_e;

endpackage

// ===== hw/rtl/oei_if.sv =====
// ----------------------------------------------------------------------------
// oei_in_if / oei_out_if
// Valid/ready channels carrying input beats and result beats.
// ----------------------------------------------------------------------------
interface oei_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [47:0] load_pos_x;
  logic signed [47:0] load_pos_y;
  logic signed [47:0] load_pos_z;
  logic signed [47:0] load_vel_x;
  logic signed [47:0] load_vel_y;
  logic signed [47:0] load_vel_z;

  modport source (
    output valid, cmd, load_pos_x, load_pos_y, load_pos_z,
           load_vel_x, load_vel_y, load_vel_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, load_pos_x, load_pos_y, load_pos_z,
           load_vel_x, load_vel_y, load_vel_z,
    output ready
  );
endinterface

interface oei_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [47:0] pos_z;
  logic signed [47:0] vel_x;
  logic signed [47:0] vel_y;
  logic signed [47:0] vel_z;
  logic               degenerate;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, degenerate,
    output ready
  );
endinterface

// ===== hw/rtl/orbit_euler_integrator.sv =====
// Sequencing: a load beat's result beat is valid the cycle after it is taken; a step
// beat runs six squares, then a divide in the divider (skipped on zero position),
// then up to twelve products, all on the shared multiplier built on one 24x24 unit.
// Throughput: one beat at a time; ready only while idle.
// Reset: position and velocity clear to zero, inverse_mass and step_time to 1.0.
// ----------------------------------------------------------------------------
// orbit_euler_integrator
// Semi-implicit Euler integrator for one body, sequenced over one shared
// multiplier and a divider.
// ----------------------------------------------------------------------------
module orbit_euler_integrator #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  oei_in_if.sink                        in_i,
  oei_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [oei_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [oei_pkg::DataW-1:0]     cfg_data_i
);
  import oei_pkg::*;

  localparam uword_t One = uword_t'(1) << FRAC_BITS;

  function automatic uword_t mag(input word_t a);
    return a[DataW-1] ? uword_t'(-a) : uword_t'(a);
  endfunction

  function automatic word_t fix(input prod_t p, input logic neg);
    prod_t  m;
    uword_t lim, v;
    m   = p >> FRAC_BITS;
    lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    v   = (m > {{(ProdW-DataW){1'b0}}, lim}) ? lim : m[DataW-1:0];
    return neg ? word_t'(-v) : word_t'(v);
  endfunction

  function automatic word_t sadd(input word_t a, input word_t b);
    logic signed [DataW:0] s;
    s = {a[DataW-1], a} + {b[DataW-1], b};
    if (s[DataW] != s[DataW-1]) begin
      return s[DataW] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end
    return s[DataW-1:0];
  endfunction

  // configuration
  uword_t invm_q, dt_q;
  word_t  thr_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invm_q <= One;
      dt_q   <= One;
      thr_q  <= '{default: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INV_MASS:  invm_q   <= cfg_data_i;
        CFG_THRUST_X:  thr_q[0] <= cfg_data_i;
        CFG_THRUST_Y:  thr_q[1] <= cfg_data_i;
        CFG_THRUST_Z:  thr_q[2] <= cfg_data_i;
        CFG_STEP_TIME: dt_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and datapath state
  state_e     state_q, state_d;
  word_t      pos_q [3], pos_d [3];
  word_t      vel_q [3], vel_d [3];
  prod_t      sp_q, sp_d, sv_q, sv_d;
  uword_t     k_q, k_d;
  word_t      acc_q, acc_d;
  logic       degen_q, degen_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] ax_q, ax_d;
  logic       mgo_q, mgo_d, dgo_q, dgo_d;

  uword_t     ma, mb, quot;
  prod_t      prod;
  logic       mdone, ddone;
  word_t      sq_op;

  oei_mul u_mul (
    .clk_i, .rst_ni,
    .start_i (mgo_q),
    .a_i     (ma),
    .b_i     (mb),
    .done_o  (mdone),
    .prod_o  (prod)
  );

  oei_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i (dgo_q),
    .num_i   (sv_q),
    .den_i   (sp_q),
    .done_o  (ddone),
    .quot_o  (quot)
  );

  always_comb begin
    sq_op = (cnt_q < 3'd3) ? pos_q[cnt_q[1:0]] : vel_q[2'(cnt_q - 3'd3)];
    ma = '0;
    mb = '0;
    case (state_q)
      ST_SQR: begin
        ma = mag(sq_op);
        mb = mag(sq_op);
      end
      ST_THR: begin
        ma = mag(thr_q[ax_q]);
        mb = invm_q;
      end
      ST_CEN: begin
        ma = mag(pos_q[ax_q]);
        mb = k_q;
      end
      ST_VEL: begin
        ma = mag(acc_q);
        mb = dt_q;
      end
      ST_POS: begin
        ma = mag(vel_q[ax_q]);
        mb = dt_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    vel_d   = vel_q;
    sp_d    = sp_q;
    sv_d    = sv_q;
    k_d     = k_q;
    acc_d   = acc_q;
    degen_d = degen_q;
    cnt_d   = cnt_q;
    ax_d    = ax_q;
    mgo_d   = 1'b0;
    dgo_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (in_i.cmd) begin
            pos_d   = '{in_i.load_pos_x, in_i.load_pos_y, in_i.load_pos_z};
            vel_d   = '{in_i.load_vel_x, in_i.load_vel_y, in_i.load_vel_z};
            degen_d = 1'b0;
            state_d = ST_OUT;
          end else begin
            sp_d    = '0;
            sv_d    = '0;
            cnt_d   = '0;
            mgo_d   = 1'b1;
            state_d = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mdone) begin
          if (cnt_q < 3'd3) begin
            sp_d = sp_q + prod;
          end else begin
            sv_d = sv_q + prod;
          end
          if (cnt_q == 3'd5) begin
            ax_d = '0;
            if (sp_q == '0) begin
              degen_d = 1'b1;
              k_d     = '0;
              mgo_d   = 1'b1;
              state_d = ST_THR;
            end else begin
              degen_d = 1'b0;
              dgo_d   = 1'b1;
              state_d = ST_DIV;
            end
          end else begin
            cnt_d = cnt_q + 3'd1;
            mgo_d = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (ddone) begin
          k_d     = quot;
          mgo_d   = 1'b1;
          state_d = ST_THR;
        end
      end
      ST_THR: begin
        if (mdone) begin
          acc_d   = fix(prod, thr_q[ax_q][DataW-1]);
          mgo_d   = 1'b1;
          state_d = degen_q ? ST_VEL : ST_CEN;
        end
      end
      ST_CEN: begin
        if (mdone) begin
          acc_d   = sadd(acc_q, fix(prod, ~pos_q[ax_q][DataW-1]));
          mgo_d   = 1'b1;
          state_d = ST_VEL;
        end
      end
      ST_VEL: begin
        if (mdone) begin
          vel_d[ax_q] = sadd(vel_q[ax_q], fix(prod, acc_q[DataW-1]));
          mgo_d       = 1'b1;
          state_d     = ST_POS;
        end
      end
      ST_POS: begin
        if (mdone) begin
          pos_d[ax_q] = sadd(pos_q[ax_q], fix(prod, vel_q[ax_q][DataW-1]));
          if (ax_q == 2'd2) begin
            state_d = ST_OUT;
          end else begin
            ax_d    = ax_q + 2'd1;
            mgo_d   = 1'b1;
            state_d = ST_THR;
          end
        end
      end
      ST_OUT: begin
        if (out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '{default: '0};
      vel_q   <= '{default: '0};
      degen_q <= 1'b0;
      cnt_q   <= '0;
      ax_q    <= '0;
      mgo_q   <= 1'b0;
      dgo_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      vel_q   <= vel_d;
      degen_q <= degen_d;
      cnt_q   <= cnt_d;
      ax_q    <= ax_d;
      mgo_q   <= mgo_d;
      dgo_q   <= dgo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q  <= sp_d;
    sv_q  <= sv_d;
    k_q   <= k_d;
    acc_q <= acc_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = (state_q == ST_OUT);
  assign out_o.pos_x      = pos_q[0];
  assign out_o.pos_y      = pos_q[1];
  assign out_o.pos_z      = pos_q[2];
  assign out_o.vel_x      = vel_q[0];
  assign out_o.vel_y      = vel_q[1];
  assign out_o.vel_z      = vel_q[2];
  assign out_o.degenerate = degen_q;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while result beat pending");

  a_mul_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mgo_q |-> (state_q == ST_SQR || state_q == ST_THR || state_q == ST_CEN ||
               state_q == ST_VEL || state_q == ST_POS))
    else $error("multiplier started outside a product state");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> sp_q != '0)
    else $error("divide by zero position magnitude");

  a_degen_skips_cen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CEN) |-> !degen_q)
    else $error("centripetal term on zero position");
`endif

endmodule

// ===== hw/rtl/oei_mul.sv =====
// ----------------------------------------------------------------------------
// oei_mul
// 48x48 unsigned multiplier built from one 24x24 unit over four partial products.
// ----------------------------------------------------------------------------
module oei_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  oei_pkg::uword_t      a_i,
  input  oei_pkg::uword_t      b_i,
  output logic                 done_o,
  output oei_pkg::prod_t       prod_o
);
  import oei_pkg::*;

  uword_t           a_q, b_q;
  prod_t            acc_q;
  logic [1:0]       phase_q;
  logic             busy_q, done_q;
  logic [HalfW-1:0] op_a, op_b;
  logic [DataW-1:0] pp;
  prod_t            pp_sh;

  always_comb begin
    op_a  = phase_q[1] ? a_q[DataW-1:HalfW] : a_q[HalfW-1:0];
    op_b  = phase_q[0] ? b_q[DataW-1:HalfW] : b_q[HalfW-1:0];
    pp    = op_a * op_b;
    pp_sh = ProdW'(pp) << (HalfW * (32'(phase_q[1]) + 32'(phase_q[0])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= '0;
      end else if (busy_q) begin
        phase_q <= phase_q + 2'd1;
        if (phase_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hw/rtl/oei_div.sv =====
// ----------------------------------------------------------------------------
// oei_div
// Restoring divider, one quotient bit a cycle: floor(num * 2^frac / den),
// saturated to 48 bits.
// ----------------------------------------------------------------------------
module oei_div #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  oei_pkg::prod_t   num_i,
  input  oei_pkg::prod_t   den_i,
  output logic             done_o,
  output oei_pkg::uword_t  quot_o
);
  import oei_pkg::*;

  localparam int unsigned Steps = ProdW + FRAC_BITS;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  prod_t           num_q, den_q, rem_q;
  uword_t          quo_q;
  logic            sat_q, busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [ProdW:0]  rem_sh, rem_nx;
  logic            ge;
  logic [DataW:0]  quo_w;

  always_comb begin
    rem_sh = {rem_q, num_q[ProdW-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
    quo_w  = {quo_q, ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      sat_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_nx[ProdW-1:0];
      quo_q <= quo_w[DataW-1:0];
      sat_q <= sat_q | quo_w[DataW];
    end
  end

  assign done_o = done_q;
  assign quot_o = sat_q ? '1 : quo_q;

endmodule
